### rtl/id3fw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_pkg
// Shared types and constants of the ID3v2.4 frame walker.
// ----------------------------------------------------------------------------
package id3fw_pkg;

  localparam int HEADER_BYTES = 10;
  localparam int BODY_LIMIT   = 256;

  localparam logic [15:0] MIN_VERSION_RESET = 16'h0400;
  localparam logic [31:0] ID3_MAGIC  = 32'h0049_4433;
  localparam logic [7:0]  CHAR_SLASH = 8'h2f;
  localparam logic [30:0] MAX31      = 31'h7fff_ffff;

  localparam logic [2:0] EV_FRAME   = 3'd0;
  localparam logic [2:0] EV_TRACK   = 3'd1;
  localparam logic [2:0] EV_LENGTH  = 3'd2;
  localparam logic [2:0] EV_TAG_END = 3'd3;
  localparam logic [2:0] EV_BAD_MAG = 3'd4;
  localparam logic [2:0] EV_BAD_VER = 3'd5;

  localparam logic [3:0] KIND_TRCK = 4'd3;
  localparam logic [3:0] KIND_TLEN = 4'd9;
  localparam logic [3:0] KIND_NONE = 4'd11;

  localparam logic [31:0] ID_TABLE [11] = '{
    32'h5450_4531, 32'h5449_5432, 32'h5441_4C42, 32'h5452_434B,
    32'h5443_4F4E, 32'h5444_5243, 32'h5453_5345, 32'h5443_4D50,
    32'h5450_4532, 32'h544C_454E, 32'h4150_4943
  };

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [31:0] id_word;
    logic [3:0]  frame_kind;
    logic [27:0] size_word;
    logic [30:0] value_a;
    logic [30:0] value_b;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } push_t;

  function automatic logic [3:0] kind_of(input logic [31:0] id);
    logic [3:0] k;
    k = KIND_NONE;
    for (int i = 10; i >= 0; i--) begin
      if (ID_TABLE[i] == id) k = 4'(i);
    end
    return k;
  endfunction

endpackage

### rtl/id3fw_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_parse
// Byte-wide parser state and the results that one byte produces.
// ----------------------------------------------------------------------------
module id3fw_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic              first,
  input  logic [15:0]       min_version,
  output id3fw_pkg::push_t  push
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_TAG   = 3'd1;
  localparam logic [2:0] PH_FRAME = 3'd2;
  localparam logic [2:0] PH_BODY  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [27:0] field_count, field_count_next;
  logic [27:0] tag_bytes, tag_bytes_next;
  logic [27:0] consumed, consumed_next;
  logic [31:0] id_shift, id_shift_next;
  logic [27:0] size_shift, size_shift_next;
  logic [15:0] version_word, version_word_next;
  logic [3:0]  current_kind, current_kind_next;
  logic [30:0] number_one, number_one_next;
  logic [30:0] number_two, number_two_next;
  logic        slash_seen, slash_seen_next;
  logic        digits_done, digits_done_next;

  logic [2:0]  ph_c;
  logic [27:0] fc_c, fc_inc, cons_sum, size_in;
  logic        head_v, end_v, digit, win;
  id3fw_pkg::res_t head, tag_end;

  function automatic logic [30:0] add_digit(input logic [30:0] v, input logic [7:0] c);
    logic [34:0] t;
    t = 35'({v, 3'b000}) + 35'({v, 1'b0}) + 35'(c[3:0]);
    return (t > 35'(id3fw_pkg::MAX31)) ? id3fw_pkg::MAX31 : t[30:0];
  endfunction

  function automatic logic [27:0] sat_add(input logic [27:0] a, input logic [27:0] b);
    logic [28:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[28] ? '1 : t[27:0];
  endfunction

  function automatic id3fw_pkg::res_t mk(input logic [2:0] ek, input logic [31:0] id,
                                         input logic [3:0] fk, input logic [27:0] sz,
                                         input logic [30:0] a, input logic [30:0] b);
    id3fw_pkg::res_t r;
    r.event_kind = ek;
    r.id_word    = id;
    r.frame_kind = fk;
    r.size_word  = sz;
    r.value_a    = a;
    r.value_b    = b;
    r.last       = 1'b0;
    return r;
  endfunction

  always_comb begin
    ph_c              = first ? PH_TAG : phase;
    fc_c              = first ? '0 : field_count;
    phase_next        = ph_c;
    field_count_next  = fc_c;
    tag_bytes_next    = first ? '0 : tag_bytes;
    consumed_next     = first ? '0 : consumed;
    id_shift_next     = first ? '0 : id_shift;
    size_shift_next   = first ? '0 : size_shift;
    version_word_next = first ? '0 : version_word;
    current_kind_next = first ? id3fw_pkg::KIND_NONE : current_kind;
    number_one_next   = number_one;
    number_two_next   = number_two;
    slash_seen_next   = slash_seen;
    digits_done_next  = digits_done;
    fc_inc            = fc_c + 28'd1;
    size_in           = {size_shift_next[20:0], data_byte[6:0]};
    cons_sum          = sat_add(consumed_next, size_shift_next);
    digit             = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    win               = (fc_c >= 28'd1) && (fc_c < 28'(id3fw_pkg::BODY_LIMIT));
    head_v            = 1'b0;
    end_v             = 1'b0;
    head              = mk(id3fw_pkg::EV_FRAME, '0, id3fw_pkg::KIND_NONE, '0, '0, '0);

    case (ph_c)
      PH_TAG: begin
        if (fc_c < 28'd3) id_shift_next = {id_shift_next[23:0], data_byte};
        else if (fc_c < 28'd5) version_word_next = {version_word_next[7:0], data_byte};
        else if (fc_c >= 28'd6) size_shift_next = size_in;
        field_count_next = fc_inc;
        if (fc_inc >= 28'(id3fw_pkg::HEADER_BYTES)) begin
          tag_bytes_next = size_shift_next;
          if (id_shift_next != id3fw_pkg::ID3_MAGIC) begin
            head_v     = 1'b1;
            head       = mk(id3fw_pkg::EV_BAD_MAG, '0, id3fw_pkg::KIND_NONE, '0, '0, '0);
            phase_next = PH_DONE;
          end else if (version_word_next < min_version) begin
            head_v     = 1'b1;
            head       = mk(id3fw_pkg::EV_BAD_VER, '0, id3fw_pkg::KIND_NONE,
                            size_shift_next, 31'(version_word_next), '0);
            phase_next = PH_DONE;
          end else if (size_shift_next == '0) begin
            end_v      = 1'b1;
            phase_next = PH_DONE;
          end else begin
            consumed_next    = '0;
            phase_next       = PH_FRAME;
            field_count_next = '0;
            id_shift_next    = '0;
            size_shift_next  = '0;
          end
        end
      end
      PH_FRAME: begin
        if (fc_c < 28'd4) id_shift_next = {id_shift_next[23:0], data_byte};
        else if (fc_c < 28'd8) size_shift_next = size_in;
        field_count_next = fc_inc;
        if (fc_inc >= 28'(id3fw_pkg::HEADER_BYTES)) begin
          consumed_next = sat_add(consumed_next, 28'(id3fw_pkg::HEADER_BYTES));
          if (id_shift_next[31:24] == 8'd0) begin
            end_v      = 1'b1;
            phase_next = PH_DONE;
          end else begin
            current_kind_next = id3fw_pkg::kind_of(id_shift_next);
            head_v = 1'b1;
            head   = mk(id3fw_pkg::EV_FRAME, id_shift_next, current_kind_next,
                        size_shift_next, '0, '0);
            field_count_next = '0;
            number_one_next  = '0;
            number_two_next  = '0;
            slash_seen_next  = 1'b0;
            digits_done_next = 1'b0;
            if (size_shift_next == '0) begin
              if (consumed_next >= tag_bytes_next) begin
                end_v      = 1'b1;
                phase_next = PH_DONE;
              end else begin
                phase_next = PH_FRAME;
                id_shift_next = '0;
              end
            end else begin
              phase_next = PH_BODY;
            end
          end
        end
      end
      PH_BODY: begin
        if (win) begin
          if (current_kind_next == id3fw_pkg::KIND_TRCK) begin
            if (!slash_seen) begin
              if (data_byte == id3fw_pkg::CHAR_SLASH) begin
                slash_seen_next  = 1'b1;
                digits_done_next = 1'b0;
              end else if (!digits_done) begin
                if (digit) number_one_next = add_digit(number_one, data_byte);
                else digits_done_next = 1'b1;
              end
            end else if (!digits_done) begin
              if (digit) number_two_next = add_digit(number_two, data_byte);
              else digits_done_next = 1'b1;
            end
          end else if (current_kind_next == id3fw_pkg::KIND_TLEN && !digits_done) begin
            if (digit) number_one_next = add_digit(number_one, data_byte);
            else digits_done_next = 1'b1;
          end
        end
        field_count_next = fc_inc;
        if (fc_inc >= size_shift_next) begin
          if (current_kind_next == id3fw_pkg::KIND_TRCK && slash_seen_next) begin
            head_v = 1'b1;
            head   = mk(id3fw_pkg::EV_TRACK, id_shift_next, current_kind_next,
                        size_shift_next, number_one_next, number_two_next);
          end else if (current_kind_next == id3fw_pkg::KIND_TLEN) begin
            head_v = 1'b1;
            head   = mk(id3fw_pkg::EV_LENGTH, id_shift_next, current_kind_next,
                        size_shift_next, number_one_next, '0);
          end
          consumed_next = cons_sum;
          if (cons_sum >= tag_bytes_next) begin
            end_v      = 1'b1;
            phase_next = PH_DONE;
          end else begin
            phase_next       = PH_FRAME;
            field_count_next = '0;
            id_shift_next    = '0;
            size_shift_next  = '0;
          end
        end
      end
      default: begin
      end
    endcase

    if (phase_next == PH_FRAME && field_count_next == '0) size_shift_next = '0;

    tag_end    = mk(id3fw_pkg::EV_TAG_END, '0, id3fw_pkg::KIND_NONE, tag_bytes_next, '0, '0);
    push.count = step ? ({1'b0, head_v} + {1'b0, end_v}) : 2'd0;
    push.res0  = head_v ? head : tag_end;
    push.res1  = tag_end;
    if (head_v && end_v) push.res1.last = 1'b1;
    else push.res0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      field_count  <= '0;
      tag_bytes    <= '0;
      consumed     <= '0;
      id_shift     <= '0;
      size_shift   <= '0;
      version_word <= '0;
      current_kind <= id3fw_pkg::KIND_NONE;
      number_one   <= '0;
      number_two   <= '0;
      slash_seen   <= 1'b0;
      digits_done  <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      field_count  <= field_count_next;
      tag_bytes    <= tag_bytes_next;
      consumed     <= consumed_next;
      id_shift     <= id_shift_next;
      size_shift   <= size_shift_next;
      version_word <= version_word_next;
      current_kind <= current_kind_next;
      number_one   <= number_one_next;
      number_two   <= number_two_next;
      slash_seen   <= slash_seen_next;
      digits_done  <= digits_done_next;
    end
  end

endmodule

### rtl/id3fw_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_outq
// Four-entry result queue: up to two items in, one item out per cycle while out_stall is low.
// ----------------------------------------------------------------------------
module id3fw_outq (
  input  logic              clk,
  input  logic              rst,
  input  id3fw_pkg::push_t  push,
  output logic              full,
  output logic              out_valid,
  input  logic              out_stall,
  output id3fw_pkg::res_t   head
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  id3fw_pkg::res_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [AW:0]     count, count_next;
  logic            pop;

  assign out_valid = (count != '0);
  assign head      = mem[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // room for two more results is needed before a byte is taken
  assign full      = (count > (AW + 1)'(DEPTH - 2));

  always_comb begin
    count_next = count + (AW + 1)'(push.count) - (AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.res0;
    if (push.count == 2'd2) mem[wr_ptr + AW'(1)] <= push.res1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(push.count);
      rd_ptr <= rd_ptr + AW'(pop);
      count  <= count_next;
    end
  end

endmodule

### rtl/id3v24_frame_walker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v24_frame_walker_core
// ID3v2.4 tag header check and frame header walk, one file byte per item.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle and updates its parser state in that
// cycle; a byte yields zero, one or two result items, which go into a
// four-entry result queue that delivers one item per cycle while out_stall
// is low. Input stalls only while fewer than two queue slots are free, so the
// byte rate is one per cycle as long as results are taken; the single output
// port sets the limit when bytes produce results faster than one per cycle.
// There is no clearing pass after reset.
module id3v24_frame_walker_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  event_kind,
  output logic [31:0] id_word,
  output logic [3:0]  frame_kind,
  output logic [27:0] size_word,
  output logic [30:0] value_a,
  output logic [30:0] value_b,
  output logic        last
);

  logic [15:0]      min_version;
  logic             full;
  id3fw_pkg::push_t push;
  id3fw_pkg::res_t  head;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_version <= id3fw_pkg::MIN_VERSION_RESET;
    end else if (cfg_wr) begin
      min_version <= cfg_data;
    end
  end

  assign in_stall = full;

  id3fw_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (in_valid && !full),
    .data_byte   (data_byte),
    .first       (first),
    .min_version (min_version),
    .push        (push)
  );

  id3fw_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign event_kind = head.event_kind;
  assign id_word    = head.id_word;
  assign frame_kind = head.frame_kind;
  assign size_word  = head.size_word;
  assign value_a    = head.value_a;
  assign value_b    = head.value_b;
  assign last       = head.last;

endmodule

### rtl/id3fw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_checker
// Port-level checks of the frame walker, bound to the top level.
// ----------------------------------------------------------------------------
module id3fw_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  event_kind,
  input logic [31:0] id_word,
  input logic [3:0]  frame_kind,
  input logic [27:0] size_word,
  input logic        last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(id_word)
      && $stable(size_word) && $stable(last))
    else $error("stalled result item changed");

  a_tag_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == id3fw_pkg::EV_TAG_END
      |-> last && id_word == '0 && frame_kind == id3fw_pkg::KIND_NONE)
    else $error("tag end item malformed");

  a_bad_magic: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == id3fw_pkg::EV_BAD_MAG |-> last && size_word == '0)
    else $error("bad magic item malformed");

  a_value_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_kind == id3fw_pkg::EV_TRACK || event_kind == id3fw_pkg::EV_LENGTH)
      |-> (event_kind == id3fw_pkg::EV_TRACK && frame_kind == id3fw_pkg::KIND_TRCK)
       || (event_kind == id3fw_pkg::EV_LENGTH && frame_kind == id3fw_pkg::KIND_TLEN))
    else $error("value item from wrong frame kind");

endmodule

bind id3v24_frame_walker_core id3fw_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .event_kind (event_kind),
  .id_word    (id_word),
  .frame_kind (frame_kind),
  .size_word  (size_word),
  .last       (last)
);

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ID3v2.4 frame walker core.
//
// A short table of header bytes comes first: an ignored byte, a bad magic, a
// rejected version and an empty tag, with their results typed in. Random
// files follow, mostly well-formed tags with TRCK, TLEN, table and unknown
// frames, some with padding, overrun, truncation or a broken header. Every
// accepted byte runs through a byte-level walker model in the bench, and each
// result item is compared field by field with the oldest expected event.
// The minimum version is changed between phases while the core is idle, and
// both sides idle in random bursts, with one long output hold.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 300;
  localparam int PHASE_LEN = 360;

  typedef enum logic [2:0] {W_IDLE, W_TAG, W_FRAME, W_BODY, W_DONE} walk_t;

  typedef struct packed {
    logic [7:0]  b;
    logic        f;
    logic        typed;
    logic [2:0]  ev;
    logic [27:0] size;
    logic [30:0] va;
  } dir_row_t;

  localparam dir_row_t DIR_TAB [31] = '{
    '{8'h55, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b1, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b1, id3fw_pkg::EV_BAD_MAG, 28'd0,   31'd0},
    '{8'h49, 1'b1, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h44, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h33, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h03, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h01, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b1, id3fw_pkg::EV_BAD_VER, 28'd128, 31'h3ff},
    '{8'h49, 1'b1, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h44, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h33, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h04, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h00, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'hff, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h80, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h80, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h80, 1'b0, 1'b0, id3fw_pkg::EV_FRAME,   28'd0,   31'd0},
    '{8'h80, 1'b0, 1'b1, id3fw_pkg::EV_TAG_END, 28'd0,   31'd0}
  };

  logic        clk;
  logic        rst;
  logic        cfg_wr;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  event_kind;
  logic [31:0] id_word;
  logic [3:0]  frame_kind;
  logic [27:0] size_word;
  logic [30:0] value_a;
  logic [30:0] value_b;
  logic        last;

  // walker model state
  walk_t       w_phase;
  logic [15:0] w_min_ver;
  logic [27:0] w_cnt;
  logic [27:0] w_tag_len;
  logic [27:0] w_used;
  logic [27:0] w_size;
  logic [31:0] w_id;
  logic [15:0] w_ver;
  logic [3:0]  w_kind;
  logic [30:0] w_num_a;
  logic [30:0] w_num_b;
  logic        w_slash;
  logic        w_digits_end;

  id3fw_pkg::res_t step_events[$];
  id3fw_pkg::res_t pending_events[$];
  id3fw_pkg::res_t head_event;
  logic [7:0]  body_txt[$];
  logic [7:0]  file_bytes[$];

  int          errors;
  int          cycles;
  int          bytes_sent;
  bit          quiet;
  bit          held;
  int          hold_left;

  id3v24_frame_walker_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .first      (first),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .event_kind (event_kind),
    .id_word    (id_word),
    .frame_kind (frame_kind),
    .size_word  (size_word),
    .value_a    (value_a),
    .value_b    (value_b),
    .last       (last)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [30:0] dec_push(input logic [30:0] v, input logic [7:0] c);
    logic [35:0] t;
    t = 36'(v) * 36'd10 + 36'(c - 8'h30);
    return (t > 36'(id3fw_pkg::MAX31)) ? id3fw_pkg::MAX31 : t[30:0];
  endfunction

  task walker_reset();
    w_min_ver    = id3fw_pkg::MIN_VERSION_RESET;
    w_phase      = W_IDLE;
    w_cnt        = '0;
    w_tag_len    = '0;
    w_used       = '0;
    w_size       = '0;
    w_id         = '0;
    w_ver        = '0;
    w_kind       = id3fw_pkg::KIND_NONE;
    w_num_a      = '0;
    w_num_b      = '0;
    w_slash      = 1'b0;
    w_digits_end = 1'b0;
  endtask

  task emit(input logic [2:0] ev, input logic [31:0] id, input logic [3:0] k,
            input logic [27:0] sz, input logic [30:0] a, input logic [30:0] bv);
    id3fw_pkg::res_t r;
    r = '{event_kind: ev, id_word: id, frame_kind: k, size_word: sz,
          value_a: a, value_b: bv, last: 1'b0};
    step_events.push_back(r);
  endtask

  task used_add(input logic [27:0] k);
    logic [28:0] t;
    t = {1'b0, w_used} + {1'b0, k};
    w_used = t[28] ? 28'hfff_ffff : t[27:0];
  endtask

  task tag_close();
    emit(id3fw_pkg::EV_TAG_END, '0, id3fw_pkg::KIND_NONE, w_tag_len, '0, '0);
    w_phase = W_DONE;
  endtask

  task hdr_start();
    w_phase = W_FRAME;
    w_cnt   = '0;
    w_id    = '0;
    w_size  = '0;
  endtask

  task frame_close();
    if (w_kind == id3fw_pkg::KIND_TRCK && w_slash) begin
      emit(id3fw_pkg::EV_TRACK, w_id, w_kind, w_size, w_num_a, w_num_b);
    end
    if (w_kind == id3fw_pkg::KIND_TLEN && w_size != 0) begin
      emit(id3fw_pkg::EV_LENGTH, w_id, w_kind, w_size, w_num_a, '0);
    end
    used_add(w_size);
    if (w_used >= w_tag_len) tag_close();
    else hdr_start();
  endtask

  // one file byte through the walker; results land in step_events
  task walk_byte(input logic [7:0] b, input logic f);
    logic is_digit;
    id3fw_pkg::res_t r;
    int   i;
    step_events.delete();
    is_digit = (b >= 8'h30) && (b <= 8'h39);
    if (f) begin
      w_phase   = W_TAG;
      w_cnt     = '0;
      w_id      = '0;
      w_size    = '0;
      w_ver     = '0;
      w_tag_len = '0;
      w_used    = '0;
      w_kind    = id3fw_pkg::KIND_NONE;
    end
    case (w_phase)
      W_TAG: begin
        if (w_cnt < 3) w_id = {w_id[23:0], b};
        else if (w_cnt < 5) w_ver = {w_ver[7:0], b};
        else if (w_cnt >= 6) w_size = {w_size[20:0], b[6:0]};
        w_cnt = w_cnt + 1'b1;
        if (w_cnt >= id3fw_pkg::HEADER_BYTES) begin
          w_tag_len = w_size;
          if (w_id != id3fw_pkg::ID3_MAGIC) begin
            emit(id3fw_pkg::EV_BAD_MAG, '0, id3fw_pkg::KIND_NONE, '0, '0, '0);
            w_phase = W_DONE;
          end else if (w_ver < w_min_ver) begin
            emit(id3fw_pkg::EV_BAD_VER, '0, id3fw_pkg::KIND_NONE, w_tag_len,
                 31'(w_ver), '0);
            w_phase = W_DONE;
          end else if (w_tag_len == 0) begin
            tag_close();
          end else begin
            w_used = '0;
            hdr_start();
          end
        end
      end
      W_FRAME: begin
        if (w_cnt < 4) w_id = {w_id[23:0], b};
        else if (w_cnt < 8) w_size = {w_size[20:0], b[6:0]};
        w_cnt = w_cnt + 1'b1;
        if (w_cnt >= id3fw_pkg::HEADER_BYTES) begin
          used_add(28'(id3fw_pkg::HEADER_BYTES));
          if (w_id[31:24] == 8'h00) begin
            tag_close();
          end else begin
            w_kind = id3fw_pkg::KIND_NONE;
            for (i = 0; i < 11; i++) begin
              if (w_kind == id3fw_pkg::KIND_NONE && id3fw_pkg::ID_TABLE[i] == w_id)
                w_kind = 4'(i);
            end
            emit(id3fw_pkg::EV_FRAME, w_id, w_kind, w_size, '0, '0);
            w_cnt        = '0;
            w_num_a      = '0;
            w_num_b      = '0;
            w_slash      = 1'b0;
            w_digits_end = 1'b0;
            if (w_size == 0) frame_close();
            else w_phase = W_BODY;
          end
        end
      end
      W_BODY: begin
        if (w_cnt >= 1 && w_cnt < id3fw_pkg::BODY_LIMIT) begin
          if (w_kind == id3fw_pkg::KIND_TRCK) begin
            if (!w_slash) begin
              if (b == id3fw_pkg::CHAR_SLASH) begin
                w_slash      = 1'b1;
                w_digits_end = 1'b0;
              end else if (!w_digits_end) begin
                if (is_digit) w_num_a = dec_push(w_num_a, b);
                else w_digits_end = 1'b1;
              end
            end else if (!w_digits_end) begin
              if (is_digit) w_num_b = dec_push(w_num_b, b);
              else w_digits_end = 1'b1;
            end
          end else if (w_kind == id3fw_pkg::KIND_TLEN && !w_digits_end) begin
            if (is_digit) w_num_a = dec_push(w_num_a, b);
            else w_digits_end = 1'b1;
          end
        end
        w_cnt = w_cnt + 1'b1;
        if (w_cnt >= w_size) frame_close();
      end
      default: begin
      end
    endcase
    if (step_events.size() > 0) begin
      r = step_events.pop_back();
      r.last = 1'b1;
      step_events.push_back(r);
    end
  endtask

  // offer one item, predict on acceptance, then maybe idle
  task put_byte(input logic [7:0] b, input logic f, input logic typed,
                input id3fw_pkg::res_t want);
    in_valid  <= 1'b1;
    data_byte <= b;
    first     <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    walk_byte(b, f);
    if (typed) pending_events.push_back(want);
    else foreach (step_events[k]) pending_events.push_back(step_events[k]);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      in_valid  <= 1'b0;
      data_byte <= 8'($urandom);
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task load_min_version(input logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr    <= 1'b0;
    w_min_ver = v;
  endtask

  task add_digits();
    int n;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) n = $urandom_range(0, 4);
    else if (pick < 9) n = $urandom_range(9, 12);
    else n = $urandom_range(250, 262);
    repeat (n) body_txt.push_back(8'h30 + 8'($urandom_range(0, 9)));
  endtask

  task send_file();
    logic [7:0]  area[$];
    logic [31:0] fid;
    logic [27:0] fsize;
    logic [27:0] tsize;
    logic [27:0] total;
    logic [23:0] magic;
    logic [15:0] ver;
    int          nfr;
    int          pick;
    int          cut;
    int          i;
    id3fw_pkg::res_t none;
    none  = '0;
    total = '0;
    area.delete();
    nfr = $urandom_range(0, 4);
    repeat (nfr) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) fid = id3fw_pkg::ID_TABLE[id3fw_pkg::KIND_TRCK];
      else if (pick < 55) fid = id3fw_pkg::ID_TABLE[id3fw_pkg::KIND_TLEN];
      else if (pick < 80) fid = id3fw_pkg::ID_TABLE[$urandom_range(0, 10)];
      else fid = $urandom;
      if ($urandom_range(0, 19) == 0) fsize = 28'($urandom_range(240, 300));
      else fsize = 28'($urandom_range(0, 12));
      for (i = 3; i >= 0; i--) area.push_back(fid[8*i +: 8]);
      for (i = 3; i >= 0; i--) area.push_back({1'($urandom), fsize[7*i +: 7]});
      area.push_back(8'($urandom));
      area.push_back(8'($urandom));
      body_txt.delete();
      body_txt.push_back(8'($urandom));
      if (fid == id3fw_pkg::ID_TABLE[id3fw_pkg::KIND_TRCK] ||
          fid == id3fw_pkg::ID_TABLE[id3fw_pkg::KIND_TLEN]) begin
        add_digits();
        if (fid == id3fw_pkg::ID_TABLE[id3fw_pkg::KIND_TRCK] &&
            $urandom_range(0, 4) != 0) begin
          body_txt.push_back(id3fw_pkg::CHAR_SLASH);
          add_digits();
        end
      end
      while (body_txt.size() < fsize) body_txt.push_back(8'($urandom));
      for (i = 0; i < fsize; i++) area.push_back(body_txt[i]);
      total = total + 28'd10 + fsize;
    end

    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      tsize = total;
    end else if (pick < 70) begin
      tsize = total + 28'($urandom_range(10, 30));
      if ($urandom_range(0, 4) != 0) repeat (10) area.push_back(8'h00);
    end else if (pick < 80) begin
      tsize = (total > 0) ? 28'($urandom_range(0, total - 1)) : '0;
    end else if (pick < 85) begin
      tsize = 28'hfff_ffff;
      repeat (10) area.push_back(8'h00);
    end else begin
      tsize = 28'($urandom_range(0, 400));
    end

    pick = $urandom_range(0, 99);
    if (pick < 10) ver = 16'($urandom);
    else if (pick < 15 && w_min_ver != 0) ver = w_min_ver - 1'b1;
    else if (pick < 25) ver = w_min_ver;
    else ver = 16'($urandom_range(w_min_ver, 16'hffff));

    magic = id3fw_pkg::ID3_MAGIC[23:0];
    if ($urandom_range(0, 19) == 0) magic[8*$urandom_range(0, 2) +: 8] = 8'($urandom);

    file_bytes.delete();
    file_bytes.push_back(magic[23:16]);
    file_bytes.push_back(magic[15:8]);
    file_bytes.push_back(magic[7:0]);
    file_bytes.push_back(ver[15:8]);
    file_bytes.push_back(ver[7:0]);
    file_bytes.push_back(8'($urandom));
    for (i = 3; i >= 0; i--) file_bytes.push_back({1'($urandom), tsize[7*i +: 7]});
    foreach (area[k]) file_bytes.push_back(area[k]);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
    end

    cut = file_bytes.size();
    if ($urandom_range(0, 24) == 0) cut = $urandom_range(1, file_bytes.size());
    for (i = 0; i < cut; i++) put_byte(file_bytes[i], (i == 0), 1'b0, none);
  endtask

  task automatic field_chk(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result item with nothing expected: event_kind %0d", event_kind);
        errors++;
      end else begin
        head_event = pending_events.pop_front();
        field_chk("event_kind", 32'(head_event.event_kind), 32'(event_kind));
        field_chk("id_word",    head_event.id_word,          id_word);
        field_chk("frame_kind", 32'(head_event.frame_kind), 32'(frame_kind));
        field_chk("size_word",  32'(head_event.size_word),  32'(size_word));
        field_chk("value_a",    32'(head_event.value_a),    32'(value_a));
        field_chk("value_b",    32'(head_event.value_b),    32'(value_b));
        field_chk("last",       32'(head_event.last),       32'(last));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[id3v24_frame_walker_core] ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold while the sender keeps going
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && bytes_sent >= 700) begin
        held      = 1'b1;
        out_stall <= 1'b1;
        hold_left = HOLD_LEN;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int          ph;
    int          goal;
    logic [15:0] mv;
    id3fw_pkg::res_t want;
    rst        = 1'b1;
    cfg_wr     = 1'b0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    data_byte  = '0;
    first      = 1'b0;
    errors     = 0;
    cycles     = 0;
    bytes_sent = 0;
    quiet      = 1'b0;
    held       = 1'b0;
    walker_reset();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_TAB[i]) begin
      want = '{event_kind: DIR_TAB[i].ev, id_word: 32'h0,
               frame_kind: id3fw_pkg::KIND_NONE, size_word: DIR_TAB[i].size,
               value_a: DIR_TAB[i].va, value_b: 31'h0, last: 1'b1};
      put_byte(DIR_TAB[i].b, DIR_TAB[i].f, DIR_TAB[i].typed, want);
    end

    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: mv = 16'h0000;
        1: mv = 16'hffff;
        2: mv = 16'h0300;
        3: mv = 16'($urandom);
        default: mv = id3fw_pkg::MIN_VERSION_RESET;
      endcase
      if (ph == 4) quiet = 1'b1;
      load_min_version(mv);
      goal = bytes_sent + PHASE_LEN;
      while (bytes_sent < goal) send_file();
    end

    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0) $display("[id3v24_frame_walker_core] OK");
    else $display("[id3v24_frame_walker_core] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/id3fw_pkg.sv
rtl/id3fw_parse.sv
rtl/id3fw_outq.sv
rtl/id3v24_frame_walker_core.sv
rtl/id3fw_checker.sv
bench/tb_top.sv
